[sv/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, off while in reset
// Clocked check, also active during reset
`ifndef ASSERT_OFF
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_RST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_RST(lbl, clk, prop, msg)
`endif

`endif

[sv/dcec_pkg.sv]
package dcec_pkg;

    localparam int MAX_ADDR_W  = 12;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 2;

    typedef logic signed [31:0] q16_t;
    typedef logic signed [16:0] operand_t;
    typedef logic signed [47:0] energy_t;

    localparam q16_t Q16_ONE  = 32'sh0001_0000;
    localparam q16_t Q16_ZERO = 32'sh0000_0000;

    typedef enum logic [2:0] {
        OP_CAL_STRIP  = 3'd0,
        OP_CAL_TUNNEL = 3'd1,
        OP_WR_HIGH    = 3'd2,
        OP_WR_LOW     = 3'd3,
        OP_WR_TUNNEL  = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        MODE_HIGH = 2'd0,
        MODE_LOW  = 2'd1,
        MODE_AUTO = 2'd2,
        MODE_NONE = 2'd3
    } gain_mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRONT_MODE = 2'd0,
        CFG_BACK_MODE  = 2'd1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        TBL_HIGH   = 2'd0,
        TBL_LOW    = 2'd1,
        TBL_TUNNEL = 2'd2
    } table_sel_t;

    typedef struct packed {
        logic                  cal;
        table_sel_t            tbl;
        logic                  zero;
        operand_t              operand;
        logic [MAX_ADDR_W-1:0] addr;
        q16_t                  gain;
        q16_t                  offset;
    } cmd_t;

endpackage

[sv/dcec_if.sv]
interface dcec_hit_if import dcec_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [2:0]         operation;
    logic [3:0]         board_index;
    logic [3:0]         channel;
    logic signed [9:0]  strip_number;
    logic signed [15:0] raw_energy;
    logic               preamp_low;
    q16_t               gain_value;
    q16_t               offset_value;

    modport source (
        output valid, operation, board_index, channel, strip_number, raw_energy,
               preamp_low, gain_value, offset_value,
        input  ready
    );
    modport sink (
        input  valid, operation, board_index, channel, strip_number, raw_energy,
               preamp_low, gain_value, offset_value,
        output ready
    );
endinterface

interface dcec_energy_if import dcec_pkg::*; ();
    logic    valid;
    logic    ready;
    energy_t calibrated_energy;

    modport source (output valid, calibrated_energy, input ready);
    modport sink (input valid, calibrated_energy, output ready);
endinterface

interface dcec_cfg_if import dcec_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

[sv/dcec_front.sv]
module dcec_front import dcec_pkg::*; #(
    parameter int STRIP_BOARDS       = 16,
    parameter int TUNNEL_BOARDS      = 16,
    parameter int CHANNELS_PER_BOARD = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    dcec_hit_if.sink    hit,
    dcec_cfg_if.sink    cfg,
    input  logic        q_full,
    input  logic        clearing,
    output logic        push,
    output cmd_t        cmd
);

    gain_mode_t front_mode_reg;
    gain_mode_t front_mode_next;
    gain_mode_t back_mode_reg;
    gain_mode_t back_mode_next;

    logic [MAX_ADDR_W-1:0] idx_full;
    logic        chan_ok;
    logic        strip_ok;
    logic        tunnel_ok;
    logic        strip_in_range;
    logic        is_front;
    gain_mode_t  mode_sel;
    gain_mode_t  mode_eff;
    operand_t    raw_x;
    operand_t    abs_raw;
    logic        keep;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        front_mode_next = front_mode_reg;
        back_mode_next  = back_mode_reg;
        if (cfg.valid)
        begin
            case (cfg_reg_t'(cfg.index))
                CFG_FRONT_MODE: front_mode_next = gain_mode_t'(cfg.data);
                CFG_BACK_MODE:  back_mode_next  = gain_mode_t'(cfg.data);
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_mode_reg <= MODE_HIGH;
            back_mode_reg  <= MODE_HIGH;
        end
        else
        begin
            front_mode_reg <= front_mode_next;
            back_mode_reg  <= back_mode_next;
        end
    end

    assign hit.ready = !q_full && !clearing;

    assign idx_full  = MAX_ADDR_W'(hit.board_index) * MAX_ADDR_W'(CHANNELS_PER_BOARD)
                     + MAX_ADDR_W'(hit.channel);
    assign chan_ok   = 32'(hit.channel) < CHANNELS_PER_BOARD;
    assign strip_ok  = chan_ok && (32'(hit.board_index) < STRIP_BOARDS);
    assign tunnel_ok = chan_ok && (32'(hit.board_index) < TUNNEL_BOARDS);

    assign strip_in_range = (hit.strip_number[9:8] == 2'b00);
    assign is_front       = !hit.strip_number[7];

    assign raw_x   = operand_t'(hit.raw_energy);
    assign abs_raw = hit.raw_energy[15] ? -raw_x : raw_x;

    always_comb
    begin
        mode_sel = is_front ? front_mode_reg : back_mode_reg;
        mode_eff = mode_sel;
        if (mode_sel == MODE_AUTO)
        begin
            mode_eff = hit.preamp_low ? MODE_LOW : MODE_HIGH;
        end
    end

    // Classify the beat: drop writes to absent entries and unused operations
    always_comb
    begin
        keep        = 1'b0;
        cmd         = '0;
        cmd.addr    = idx_full;
        cmd.gain    = hit.gain_value;
        cmd.offset  = hit.offset_value;
        cmd.operand = abs_raw;
        cmd.tbl     = TBL_HIGH;
        case (op_t'(hit.operation))
            OP_CAL_STRIP:
            begin
                keep        = 1'b1;
                cmd.cal     = 1'b1;
                cmd.tbl     = (mode_eff == MODE_LOW) ? TBL_LOW : TBL_HIGH;
                cmd.zero    = !strip_ok || !strip_in_range || (mode_eff == MODE_NONE);
                cmd.operand = is_front ? abs_raw : raw_x;
            end
            OP_CAL_TUNNEL:
            begin
                keep     = 1'b1;
                cmd.cal  = 1'b1;
                cmd.tbl  = TBL_TUNNEL;
                cmd.zero = !tunnel_ok;
            end
            OP_WR_HIGH:
            begin
                keep    = strip_ok;
                cmd.tbl = TBL_HIGH;
            end
            OP_WR_LOW:
            begin
                keep    = strip_ok;
                cmd.tbl = TBL_LOW;
            end
            OP_WR_TUNNEL:
            begin
                keep    = tunnel_ok;
                cmd.tbl = TBL_TUNNEL;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign push = hit.valid && hit.ready && keep;

endmodule

[sv/dcec_fifo.sv]
module dcec_fifo import dcec_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output cmd_t head,
    output logic empty,
    output logic full
);

    cmd_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QPTR_W:0]   count_reg;
    logic [QPTR_W:0]   count_next;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign head  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

[sv/dcec_back.sv]
`include "assert_macros.svh"

module dcec_back import dcec_pkg::*; #(
    parameter int STRIP_BOARDS       = 16,
    parameter int TUNNEL_BOARDS      = 16,
    parameter int CHANNELS_PER_BOARD = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    dcec_energy_if.source energy,
    input  cmd_t          head,
    input  logic          q_empty,
    output logic          pop,
    output logic          clearing
);

    localparam int STRIP_ENTRIES  = STRIP_BOARDS * CHANNELS_PER_BOARD;
    localparam int TUNNEL_ENTRIES = TUNNEL_BOARDS * CHANNELS_PER_BOARD;
    localparam int MAX_ENTRIES    = (STRIP_ENTRIES > TUNNEL_ENTRIES) ?
                                    STRIP_ENTRIES : TUNNEL_ENTRIES;
    localparam int SA_W = (STRIP_ENTRIES > 1) ? $clog2(STRIP_ENTRIES) : 1;
    localparam int TA_W = (TUNNEL_ENTRIES > 1) ? $clog2(TUNNEL_ENTRIES) : 1;
    localparam int CW   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam logic [CW-1:0] CLR_LAST = CW'(MAX_ENTRIES - 1);

    logic [63:0] high_mem [STRIP_ENTRIES];
    logic [63:0] low_mem  [STRIP_ENTRIES];
    logic [63:0] tun_mem  [TUNNEL_ENTRIES];

    logic [63:0] high_rd_reg;
    logic [63:0] low_rd_reg;
    logic [63:0] tun_rd_reg;

    logic          clr_active_reg;
    logic          clr_active_next;
    logic [CW-1:0] clr_cnt_reg;
    logic [CW-1:0] clr_cnt_next;

    logic          adv;
    logic          head_write;
    logic          high_we;
    logic          low_we;
    logic          tun_we;
    logic [SA_W-1:0] strip_waddr;
    logic [TA_W-1:0] tun_waddr;
    logic [63:0]     wdata;

    logic       b_valid_reg;
    logic       b_valid_next;
    table_sel_t b_tbl_reg;
    logic       b_zero_reg;
    operand_t   b_opnd_reg;

    logic               c_valid_reg;
    logic signed [48:0] c_prod_reg;
    logic signed [48:0] c_prod_next;
    q16_t               c_off_reg;
    q16_t               c_off_next;
    q16_t               slope_sel;
    q16_t               offset_sel;
    logic signed [48:0] opnd_x;
    logic signed [48:0] slope_x;

    logic    out_valid_reg;
    energy_t out_data_reg;
    energy_t out_data_next;

    assign clearing = clr_active_reg;
    assign adv      = !out_valid_reg || energy.ready;
    assign pop      = !q_empty && adv && !clr_active_reg;

    // Sweep every table entry to unity gain after reset
    always_comb
    begin
        clr_active_next = clr_active_reg;
        clr_cnt_next    = clr_cnt_reg;
        if (clr_active_reg)
        begin
            clr_cnt_next = clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == CLR_LAST)
            begin
                clr_active_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_cnt_reg    <= '0;
        end
        else
        begin
            clr_active_reg <= clr_active_next;
            clr_cnt_reg    <= clr_cnt_next;
        end
    end

    assign head_write  = pop && !head.cal;
    assign high_we     = clr_active_reg ? (32'(clr_cnt_reg) < STRIP_ENTRIES)
                                        : (head_write && (head.tbl == TBL_HIGH));
    assign low_we      = clr_active_reg ? (32'(clr_cnt_reg) < STRIP_ENTRIES)
                                        : (head_write && (head.tbl == TBL_LOW));
    assign tun_we      = clr_active_reg ? (32'(clr_cnt_reg) < TUNNEL_ENTRIES)
                                        : (head_write && (head.tbl == TBL_TUNNEL));
    assign strip_waddr = clr_active_reg ? clr_cnt_reg[SA_W-1:0] : head.addr[SA_W-1:0];
    assign tun_waddr   = clr_active_reg ? clr_cnt_reg[TA_W-1:0] : head.addr[TA_W-1:0];
    assign wdata       = clr_active_reg ? {Q16_ONE, Q16_ZERO} : {head.gain, head.offset};

    always_ff @(posedge clk)
    begin
        if (high_we)
        begin
            high_mem[strip_waddr] <= wdata;
        end
        if (adv)
        begin
            high_rd_reg <= high_mem[head.addr[SA_W-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (low_we)
        begin
            low_mem[strip_waddr] <= wdata;
        end
        if (adv)
        begin
            low_rd_reg <= low_mem[head.addr[SA_W-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (tun_we)
        begin
            tun_mem[tun_waddr] <= wdata;
        end
        if (adv)
        begin
            tun_rd_reg <= tun_mem[head.addr[TA_W-1:0]];
        end
    end

    assign b_valid_next = pop && head.cal;

    always_comb
    begin
        case (b_tbl_reg)
            TBL_HIGH:
            begin
                slope_sel  = high_rd_reg[63:32];
                offset_sel = high_rd_reg[31:0];
            end
            TBL_LOW:
            begin
                slope_sel  = low_rd_reg[63:32];
                offset_sel = low_rd_reg[31:0];
            end
            default:
            begin
                slope_sel  = tun_rd_reg[63:32];
                offset_sel = tun_rd_reg[31:0];
            end
        endcase
        opnd_x  = 49'(b_opnd_reg);
        slope_x = 49'(slope_sel);
        if (b_zero_reg)
        begin
            c_prod_next = '0;
            c_off_next  = Q16_ZERO;
        end
        else
        begin
            c_prod_next = opnd_x * slope_x;
            c_off_next  = offset_sel;
        end
    end

    assign out_data_next = energy_t'(c_prod_reg + 49'(c_off_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            b_valid_reg   <= b_valid_next;
            c_valid_reg   <= b_valid_reg;
            out_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b_tbl_reg    <= head.tbl;
            b_zero_reg   <= head.zero;
            b_opnd_reg   <= head.operand;
            c_prod_reg   <= c_prod_next;
            c_off_reg    <= c_off_next;
            out_data_reg <= out_data_next;
        end
    end

    assign energy.valid             = out_valid_reg;
    assign energy.calibrated_energy = out_data_reg;

    `ASSERT_RST(a_no_pop_in_sweep, clk, clr_active_reg |-> !pop, "queue popped during table sweep")
    `ASSERT_CLK(a_sweep_once, clk, rst_n, !clr_active_reg |=> !clr_active_reg, "table sweep restarted")
    `ASSERT_CLK(a_sweep_len, clk, rst_n, $fell(clr_active_reg) |-> $past(clr_cnt_reg) == CLR_LAST, "table sweep ended early")
    `ASSERT_CLK(a_read_to_mult, clk, rst_n, (b_valid_reg && adv) |=> c_valid_reg, "lost beat after table read")

endmodule

[sv/detector_channel_energy_calibration.sv]
// Flow: a calibrate beat waits behind earlier beats in the 4-entry queue, then passes
// the table-read, multiply and add registers; write beats give no result.
// Throughput: one beat per cycle while the output is not stalled by energy.ready low,
// set by one table read and one 17x32 multiply per beat.
// Reset: both gain modes go to high gain; after rst_n rises every table entry is swept
// to gain 1.0, offset 0, with hit.ready low; configuration writes are taken throughout.
module detector_channel_energy_calibration import dcec_pkg::*; #(
    parameter int STRIP_BOARDS       = 16,
    parameter int TUNNEL_BOARDS      = 16,
    parameter int CHANNELS_PER_BOARD = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    dcec_hit_if.sink      hit,
    dcec_energy_if.source energy,
    dcec_cfg_if.sink      cfg
);

    logic push;
    cmd_t push_cmd;
    logic pop;
    cmd_t head;
    logic q_empty;
    logic q_full;
    logic clearing;

    dcec_front #(
        .STRIP_BOARDS       (STRIP_BOARDS),
        .TUNNEL_BOARDS      (TUNNEL_BOARDS),
        .CHANNELS_PER_BOARD (CHANNELS_PER_BOARD)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .hit      (hit),
        .cfg      (cfg),
        .q_full   (q_full),
        .clearing (clearing),
        .push     (push),
        .cmd      (push_cmd)
    );

    dcec_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .empty    (q_empty),
        .full     (q_full)
    );

    dcec_back #(
        .STRIP_BOARDS       (STRIP_BOARDS),
        .TUNNEL_BOARDS      (TUNNEL_BOARDS),
        .CHANNELS_PER_BOARD (CHANNELS_PER_BOARD)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .energy   (energy),
        .head     (head),
        .q_empty  (q_empty),
        .pop      (pop),
        .clearing (clearing)
    );

endmodule

[sim/dcec_energy_checker.sv]
module dcec_energy_checker import dcec_pkg::*; (
    input  logic   clk,
    input  logic   rst_n,
    dcec_hit_if    hit,
    dcec_energy_if energy,
    dcec_cfg_if    cfg,
    output int     mismatches,
    output int     outstanding
);

    localparam int ENTRIES          = 256;
    localparam int FRONT_STRIP_LAST = 127;
    localparam int BACK_STRIP_END   = 256;
    localparam int REPORT_LIMIT     = 10;

    q16_t       strip_high_slope  [ENTRIES];
    q16_t       strip_high_offset [ENTRIES];
    q16_t       strip_low_slope   [ENTRIES];
    q16_t       strip_low_offset  [ENTRIES];
    q16_t       tunnel_slope      [ENTRIES];
    q16_t       tunnel_offset     [ENTRIES];
    gain_mode_t front_mode;
    gain_mode_t back_mode;
    energy_t    pending_energy_q[$];

    function automatic energy_t apply_gain(
        input operand_t operand,
        input q16_t     slope,
        input q16_t     intercept
    );
        longint full;
        full = longint'(operand) * longint'(slope) + longint'(intercept);
        return full[47:0];
    endfunction

    function automatic energy_t calibrate_energy(
        input logic [2:0]        op,
        input logic [7:0]        entry,
        input logic signed [9:0] strip,
        input logic signed [15:0] raw,
        input logic              switched
    );
        operand_t   signed_raw;
        operand_t   operand;
        gain_mode_t mode;
        signed_raw = raw;
        operand = (signed_raw < 0) ? -signed_raw : signed_raw;
        if (op == OP_CAL_TUNNEL)
            return apply_gain(operand, tunnel_slope[entry], tunnel_offset[entry]);
        if (strip < 0 || strip >= BACK_STRIP_END)
            return '0;
        if (strip <= FRONT_STRIP_LAST)
            mode = front_mode;
        else
        begin
            mode = back_mode;
            operand = signed_raw;
        end
        if (mode == MODE_AUTO)
            mode = switched ? MODE_LOW : MODE_HIGH;
        case (mode)
            MODE_HIGH: return apply_gain(operand, strip_high_slope[entry],
                                         strip_high_offset[entry]);
            MODE_LOW:  return apply_gain(operand, strip_low_slope[entry],
                                         strip_low_offset[entry]);
            default:   return '0;
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        energy_t    got;
        energy_t    want;
        logic [7:0] entry;
        if (!rst_n)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                strip_high_slope[i]  = Q16_ONE;
                strip_high_offset[i] = Q16_ZERO;
                strip_low_slope[i]   = Q16_ONE;
                strip_low_offset[i]  = Q16_ZERO;
                tunnel_slope[i]      = Q16_ONE;
                tunnel_offset[i]     = Q16_ZERO;
            end
            front_mode = MODE_HIGH;
            back_mode  = MODE_HIGH;
            pending_energy_q.delete();
            mismatches  = 0;
            outstanding = 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    CFG_FRONT_MODE: front_mode = gain_mode_t'(cfg.data);
                    CFG_BACK_MODE:  back_mode  = gain_mode_t'(cfg.data);
                    default: ;
                endcase
            end

            if (energy.valid && energy.ready)
            begin
                got = energy.calibrated_energy;
                if (pending_energy_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("%0t: energy beat with none expected: got %h", $time, got);
                end
                else
                begin
                    want = pending_energy_q.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT)
                            $display("%0t: calibrated_energy expected %h, got %h",
                                     $time, want, got);
                    end
                end
            end

            if (hit.valid && hit.ready)
            begin
                entry = {hit.board_index, hit.channel};
                case (hit.operation)
                    OP_CAL_STRIP, OP_CAL_TUNNEL:
                        pending_energy_q.push_back(calibrate_energy(hit.operation, entry,
                            hit.strip_number, hit.raw_energy, hit.preamp_low));
                    OP_WR_HIGH:
                    begin
                        strip_high_slope[entry]  = hit.gain_value;
                        strip_high_offset[entry] = hit.offset_value;
                    end
                    OP_WR_LOW:
                    begin
                        strip_low_slope[entry]  = hit.gain_value;
                        strip_low_offset[entry] = hit.offset_value;
                    end
                    OP_WR_TUNNEL:
                    begin
                        tunnel_slope[entry]  = hit.gain_value;
                        tunnel_offset[entry] = hit.offset_value;
                    end
                    default: ;
                endcase
            end
            outstanding = pending_energy_q.size();
        end
    end

endmodule

[sim/tb_detector_channel_energy_calibration.sv]
module tb_detector_channel_energy_calibration;
    import dcec_pkg::*;

    localparam int WATCHDOG_LIMIT    = 4000;
    localparam int LONG_STALL_CYCLES = 400;
    localparam int SETTLE_CYCLES     = 12;
    localparam int RANDOM_PHASES     = 6;
    localparam int BEATS_PER_PHASE   = 320;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED     = 2'd3;
    localparam logic [2:0]           OP_RESERVED_LO = 3'd5;
    localparam logic [2:0]           OP_RESERVED_HI = 3'd7;

    localparam q16_t Q16_MAX = 32'sh7FFF_FFFF;
    localparam q16_t Q16_MIN = 32'sh8000_0000;
    localparam q16_t Q16_NEG = 32'shFFFF_FFFF;

    localparam logic signed [15:0] RAW_MAX = 16'sh7FFF;
    localparam logic signed [15:0] RAW_MIN = 16'sh8000;

    logic clk;
    logic rst_n;
    logic long_stall;
    int   send_idle_pct;
    int   recv_idle_pct;
    int   quiet_cycles;
    int   mismatches;
    int   outstanding;

    gain_mode_t front_plan [RANDOM_PHASES] =
        '{MODE_LOW, MODE_AUTO, MODE_NONE, MODE_AUTO, MODE_HIGH, MODE_AUTO};
    gain_mode_t back_plan  [RANDOM_PHASES] =
        '{MODE_AUTO, MODE_NONE, MODE_LOW, MODE_AUTO, MODE_NONE, MODE_HIGH};

    dcec_hit_if    hit();
    dcec_energy_if energy();
    dcec_cfg_if    cfg();

    detector_channel_energy_calibration DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .hit    (hit),
        .energy (energy),
        .cfg    (cfg)
    );

    dcec_energy_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .hit         (hit),
        .energy      (energy),
        .cfg         (cfg),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic send_beat(
        input logic [2:0]         op,
        input logic [3:0]         board,
        input logic [3:0]         channel,
        input logic signed [9:0]  strip,
        input logic signed [15:0] raw,
        input logic               switched,
        input q16_t               gain,
        input q16_t               offset
    );
        while ($urandom_range(99) < send_idle_pct)
        begin
            hit.valid <= 1'b0;
            @(posedge clk);
        end
        hit.valid         <= 1'b1;
        hit.operation     <= op;
        hit.board_index   <= board;
        hit.channel       <= channel;
        hit.strip_number  <= strip;
        hit.raw_energy    <= raw;
        hit.preamp_low    <= switched;
        hit.gain_value    <= gain;
        hit.offset_value  <= offset;
        @(posedge clk);
        while (!hit.ready)
            @(posedge clk);
    endtask

    task automatic send_random_beat();
        int                 pick;
        logic [2:0]         op;
        logic [3:0]         board;
        logic [3:0]         channel;
        logic signed [9:0]  strip;
        logic signed [15:0] raw;
        q16_t               gain;
        pick = $urandom_range(99);
        if (pick < 8)
            op = 3'($urandom_range(7));
        else if (pick < 38)
            op = 3'($urandom_range(OP_WR_HIGH, OP_WR_TUNNEL));
        else if (pick < 88)
            op = OP_CAL_STRIP;
        else
            op = OP_CAL_TUNNEL;
        // favor a few hot entries so loads and reads collide
        board   = 4'($urandom_range(1) ? $urandom_range(15) : $urandom_range(1));
        channel = 4'($urandom_range(1) ? $urandom_range(15) : $urandom_range(1));
        case ($urandom_range(9))
            0, 1, 2, 3: strip = 10'($urandom_range(127));
            4, 5, 6, 7: strip = 10'($urandom_range(255, 128));
            default:    strip = 10'($urandom_range(1023));
        endcase
        if ($urandom_range(3) == 0)
            raw = $urandom_range(1) ? RAW_MAX : RAW_MIN;
        else
            raw = 16'($urandom);
        if ($urandom_range(3) == 0)
            gain = $signed($urandom_range(262143)) - 131072;
        else
            gain = $urandom;
        send_beat(op, board, channel, strip, raw, 1'($urandom_range(1)), gain, $urandom);
    endtask

    task automatic wait_drained();
        hit.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_config(input logic [CFG_IDX_W-1:0] idx, input gain_mode_t mode);
        wait_drained();
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= mode;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        cfg.valid <= 1'b0;
    endtask

    // result side: random stalls, plus one long hold on request
    initial
    begin
        energy.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (long_stall)
            begin
                energy.ready <= 1'b0;
                repeat (LONG_STALL_CYCLES) @(posedge clk);
                long_stall = 1'b0;
            end
            energy.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial
    begin
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((hit.valid && hit.ready) || (energy.valid && energy.ready) ||
                (cfg.valid && cfg.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("tb_detector_channel_energy_calibration: done, errors");
        $finish;
    end

    initial
    begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
        long_stall    = 1'b0;
        rst_n             <= 1'b0;
        hit.valid         <= 1'b0;
        hit.operation     <= OP_CAL_STRIP;
        hit.board_index   <= '0;
        hit.channel       <= '0;
        hit.strip_number  <= '0;
        hit.raw_energy    <= '0;
        hit.preamp_low    <= 1'b0;
        hit.gain_value    <= Q16_ZERO;
        hit.offset_value  <= Q16_ZERO;
        cfg.valid         <= 1'b0;
        cfg.index         <= CFG_FRONT_MODE;
        cfg.data          <= MODE_HIGH;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        write_config(CFG_FRONT_MODE, MODE_HIGH);
        write_config(CFG_BACK_MODE, MODE_HIGH);
        write_config(CFG_UNUSED, MODE_NONE);

        // reset tables, strip range edges
        send_beat(OP_CAL_STRIP, 4'd0, 4'd0, 10'sd0, RAW_MIN, 1'b0, Q16_ZERO, Q16_ZERO);
        send_beat(OP_CAL_STRIP, 4'd0, 4'd0, 10'sd127, RAW_MAX, 1'b1, Q16_ZERO, Q16_ZERO);
        send_beat(OP_CAL_STRIP, 4'd0, 4'd1, 10'sd128, RAW_MIN, 1'b0, Q16_ZERO, Q16_ZERO);
        send_beat(OP_CAL_STRIP, 4'd1, 4'd0, 10'sd255, RAW_MAX, 1'b0, Q16_ZERO, Q16_ZERO);
        send_beat(OP_CAL_STRIP, 4'd0, 4'd0, -10'sd1, RAW_MAX, 1'b0, Q16_ZERO, Q16_ZERO);
        send_beat(OP_CAL_STRIP, 4'd0, 4'd0, 10'sd256, RAW_MAX, 1'b0, Q16_ZERO, Q16_ZERO);
        send_beat(OP_CAL_STRIP, 4'd0, 4'd0, 10'sd511, RAW_MIN, 1'b0, Q16_ZERO, Q16_ZERO);
        send_beat(OP_CAL_STRIP, 4'd0, 4'd0, -10'sd512, RAW_MIN, 1'b1, Q16_ZERO, Q16_ZERO);
        send_beat(OP_CAL_TUNNEL, 4'd15, 4'd15, 10'sd0, RAW_MIN, 1'b0, Q16_ZERO, Q16_ZERO);

        // load extreme entries, then read back the high-gain and tunnel ones
        send_beat(OP_WR_HIGH, 4'd15, 4'd15, 10'sd0, 16'sd0, 1'b0, Q16_MAX, Q16_MIN);
        send_beat(OP_WR_LOW, 4'd15, 4'd15, 10'sd0, 16'sd0, 1'b0, Q16_MIN, Q16_MAX);
        send_beat(OP_WR_TUNNEL, 4'd15, 4'd15, 10'sd0, 16'sd0, 1'b0, Q16_MIN, Q16_MIN);
        send_beat(OP_WR_LOW, 4'd0, 4'd0, 10'sd0, 16'sd0, 1'b0, Q16_NEG, Q16_MAX);
        send_beat(OP_CAL_STRIP, 4'd15, 4'd15, 10'sd0, RAW_MIN, 1'b0, Q16_ZERO, Q16_ZERO);
        send_beat(OP_CAL_STRIP, 4'd15, 4'd15, 10'sd200, RAW_MIN, 1'b0, Q16_ZERO, Q16_ZERO);
        send_beat(OP_CAL_STRIP, 4'd15, 4'd15, 10'sd200, RAW_MAX, 1'b1, Q16_ZERO, Q16_ZERO);
        send_beat(OP_CAL_TUNNEL, 4'd15, 4'd15, 10'sd0, RAW_MIN, 1'b0, Q16_ZERO, Q16_ZERO);
        send_beat(OP_CAL_TUNNEL, 4'd15, 4'd15, 10'sd0, RAW_MAX, 1'b1, Q16_ZERO, Q16_ZERO);
        send_beat(OP_RESERVED_LO, 4'd15, 4'd15, 10'sd0, RAW_MIN, 1'b1, Q16_MAX, Q16_MAX);
        send_beat(OP_RESERVED_HI, 4'd0, 4'd0, 10'sd0, RAW_MAX, 1'b0, Q16_MIN, Q16_MIN);

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            if (phase < 2)
            begin
                send_idle_pct = 31;
                recv_idle_pct = 69;
            end
            else if (phase < 4)
            begin
                send_idle_pct = 69;
                recv_idle_pct = 31;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_config(CFG_FRONT_MODE, front_plan[phase]);
            write_config(CFG_BACK_MODE, back_plan[phase]);
            for (int n = 0; n < BEATS_PER_PHASE; n++)
            begin
                // hold results while beats keep coming; later drain mid-phase
                if (phase == 0 && n == 40)
                    long_stall = 1'b1;
                if (n == BEATS_PER_PHASE / 2)
                    wait_drained();
                send_random_beat();
            end
        end

        wait_drained();
        if (mismatches == 0)
            $display("tb_detector_channel_energy_calibration: done, clean");
        else
            $display("tb_detector_channel_energy_calibration: done, errors");
        $finish;
    end

endmodule
